// ===== src/gwd_pkg.sv =====
`default_nettype none

package gwd_pkg;

    localparam int GRID_MAX   = 4096;
    localparam int COORD_W    = 24;
    localparam int SIZE_W     = 16;
    localparam int CELL_W     = $clog2(GRID_MAX);
    localparam int GRID_W     = CELL_W + 1;
    localparam int NUM_LANES  = 6;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = COORD_W / DIV_BITS;
    localparam int WIN_SIDE   = 3;
    localparam int WIN_CELLS  = WIN_SIDE * WIN_SIDE;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 24;

    localparam logic [1:0] OP_ENTER = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_KEEP  = 2'd2;
    localparam logic [1:0] OP_WHOLE = 2'd3;

    localparam logic [1:0] ST_CELL  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] old_x;
        logic signed [COORD_W-1:0] old_y;
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic [1:0]                opcode;
    } in_word_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [1:0]        status;
        logic              last;
    } out_word_t;

    // Partial remainder and the dividend/quotient shift word of one divider lane.
    typedef struct packed {
        logic [SIZE_W-1:0]  rem;
        logic [COORD_W-1:0] num;
    } div_lane_t;

    // Three restoring division steps; quotient bits shift in as dividend bits shift out.
    function automatic div_lane_t div_step3(div_lane_t s, logic [SIZE_W-1:0] dvs);
        logic [SIZE_W:0] t;
        div_lane_t       r;
        r = s;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t = {r.rem, r.num[COORD_W-1]};
            if (t >= {1'b0, dvs})
            begin
                t     = t - {1'b0, dvs};
                r.num = {r.num[COORD_W-2:0], 1'b1};
            end
            else
            begin
                r.num = {r.num[COORD_W-2:0], 1'b0};
            end
            r.rem = t[SIZE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/grid_window_difference.sv =====
`default_nettype none

// Grid window difference. A word on item (two positions and an opcode) is taken
// at a clock edge where start is high and busy is low; its results come out
// on result, one per cycle, each marked by done for exactly one cycle, the
// final one with result.last set. Every item gives between one and nine
// results, back to back with no gaps. The receiver cannot stall, so the block
// holds its pipeline itself: busy is high while a multi-cell burst is being
// sent and nothing can move. An item passes in order through the input
// register, divider stage 0 with the prepared dividends, the eight-stage
// divider (three quotient bits per stage) that maps positions and map spans
// to cell indexes, then the window stage, the selection stage and the output
// stage, which drives result. An item can follow in the next cycle; the
// sustained rate is set by the number of results per item, since busy holds
// new items back during a burst. Configuration is written through cfg_we,
// cfg_index and cfg_data and must only change while no item is in flight.
module grid_window_difference
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  gwd_pkg::in_word_t                   item,
    output logic                                done,
    output gwd_pkg::out_word_t                  result,
    input  wire                                 cfg_we,
    input  wire  [gwd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [gwd_pkg::CFG_W-1:0]           cfg_data
);
    import gwd_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] lo;
        logic              narrow;
    } axis_t;

    // Configuration registers.
    logic signed [COORD_W-1:0] begin_x_reg, end_x_reg, begin_y_reg, end_y_reg;
    logic [SIZE_W-1:0]         cell_wid_reg, cell_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_x_reg  <= '0;
            end_x_reg    <= '0;
            begin_y_reg  <= '0;
            end_y_reg    <= '0;
            cell_wid_reg <= SIZE_W'(1);
            cell_len_reg <= SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BEGIN_X:  begin_x_reg  <= cfg_data;
                REG_END_X:    end_x_reg    <= cfg_data;
                REG_BEGIN_Y:  begin_y_reg  <= cfg_data;
                REG_END_Y:    end_y_reg    <= cfg_data;
                REG_CELL_WID: cell_wid_reg <= cfg_data[SIZE_W-1:0];
                REG_CELL_LEN: cell_len_reg <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // A zero cell size acts as one.
    logic [SIZE_W-1:0] div_x, div_y;
    assign div_x = (cell_wid_reg == '0) ? SIZE_W'(1) : cell_wid_reg;
    assign div_y = (cell_len_reg == '0) ? SIZE_W'(1) : cell_len_reg;

    // The whole pipeline moves together; it only freezes while the output
    // stage still has cells of a burst to send.
    logic o_valid_reg;
    logic hold, advance;
    out_word_t res_word;

    assign hold    = o_valid_reg && !res_word.last;
    assign advance = !hold;
    assign busy    = hold;

    // Input stage.
    logic     a_valid_reg;
    in_word_t a_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            a_item_reg <= item;
    end

    // Preparation: bounds check and non-negative dividends.
    function automatic logic [COORD_W-1:0] pos_diff(logic signed [COORD_W-1:0] p,
                                                    logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = {p[COORD_W-1], p} - {b[COORD_W-1], b};
        return d[COORD_W] ? '0 : d[COORD_W-1:0];
    endfunction

    logic prep_inside;
    assign prep_inside =
        (a_item_reg.old_x >= begin_x_reg) && (a_item_reg.old_x <= end_x_reg) &&
        (a_item_reg.old_y >= begin_y_reg) && (a_item_reg.old_y <= end_y_reg) &&
        (a_item_reg.new_x >= begin_x_reg) && (a_item_reg.new_x <= end_x_reg) &&
        (a_item_reg.new_y >= begin_y_reg) && (a_item_reg.new_y <= end_y_reg);

    // Lanes: span x, span y, old x, old y, new x, new y. Even lanes divide by
    // the cell width, odd lanes by the cell length.
    div_lane_t prep_lane [NUM_LANES];
    always_comb
    begin
        prep_lane[0] = '{rem: '0, num: pos_diff(end_x_reg, begin_x_reg)};
        prep_lane[1] = '{rem: '0, num: pos_diff(end_y_reg, begin_y_reg)};
        prep_lane[2] = '{rem: '0, num: pos_diff(a_item_reg.old_x, begin_x_reg)};
        prep_lane[3] = '{rem: '0, num: pos_diff(a_item_reg.old_y, begin_y_reg)};
        prep_lane[4] = '{rem: '0, num: pos_diff(a_item_reg.new_x, begin_x_reg)};
        prep_lane[5] = '{rem: '0, num: pos_diff(a_item_reg.new_y, begin_y_reg)};
    end

    // Divider pipeline; stage 0 holds the prepared dividends.
    logic      d_valid_reg  [DIV_STAGES+1];
    logic      d_inside_reg [DIV_STAGES+1];
    logic [1:0] d_op_reg    [DIV_STAGES+1];
    div_lane_t d_lane_reg   [DIV_STAGES+1][NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
                d_valid_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            d_valid_reg[0] <= a_valid_reg;
            for (int s = 1; s <= DIV_STAGES; s++)
                d_valid_reg[s] <= d_valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_inside_reg[0] <= prep_inside;
            d_op_reg[0]     <= a_item_reg.opcode;
            for (int l = 0; l < NUM_LANES; l++)
                d_lane_reg[0][l] <= prep_lane[l];
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                d_inside_reg[s] <= d_inside_reg[s-1];
                d_op_reg[s]     <= d_op_reg[s-1];
                for (int l = 0; l < NUM_LANES; l++)
                    d_lane_reg[s][l] <= div_step3(d_lane_reg[s-1][l],
                                                  (l % 2 == 0) ? div_x : div_y);
            end
        end
    end

    // Grid size, cell clamp and window placement along one axis.
    function automatic logic [GRID_W-1:0] grid_of(logic [COORD_W-1:0] q);
        if (q >= COORD_W'(GRID_MAX - 3))
            return GRID_W'(GRID_MAX);
        else
            return q[GRID_W-1:0] + GRID_W'(3);
    endfunction

    function automatic axis_t place(logic [COORD_W-1:0] q, logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] gm1, c;
        axis_t a;
        gm1 = g - GRID_W'(1);
        c   = (q >= {{(COORD_W-GRID_W){1'b0}}, gm1}) ? gm1 : q[GRID_W-1:0];
        if (c == '0)
        begin
            a.lo     = '0;
            a.narrow = 1'b1;
        end
        else if (c >= gm1)
        begin
            a.lo     = CELL_W'(g - GRID_W'(2));
            a.narrow = 1'b1;
        end
        else
        begin
            a.lo     = CELL_W'(c - GRID_W'(1));
            a.narrow = 1'b0;
        end
        return a;
    endfunction

    logic [GRID_W-1:0] gx, gy;
    assign gx = grid_of(d_lane_reg[DIV_STAGES][0].num);
    assign gy = grid_of(d_lane_reg[DIV_STAGES][1].num);

    logic       w_valid_reg, w_inside_reg;
    logic [1:0] w_op_reg;
    axis_t      w_ox_reg, w_oy_reg, w_nx_reg, w_ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else if (advance)
            w_valid_reg <= d_valid_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w_inside_reg <= d_inside_reg[DIV_STAGES];
            w_op_reg     <= d_op_reg[DIV_STAGES];
            w_ox_reg     <= place(d_lane_reg[DIV_STAGES][2].num, gx);
            w_oy_reg     <= place(d_lane_reg[DIV_STAGES][3].num, gy);
            w_nx_reg     <= place(d_lane_reg[DIV_STAGES][4].num, gx);
            w_ny_reg     <= place(d_lane_reg[DIV_STAGES][5].num, gy);
        end
    end

    // Selection mask over the listed window, x outer and y inner. Leaving
    // cells list the old window tested against the new; all others list the
    // new window tested against the old.
    function automatic logic in_axis(logic [GRID_W-1:0] v, axis_t a);
        logic [GRID_W-1:0] lo, hi;
        lo = {1'b0, a.lo};
        hi = lo + (a.narrow ? GRID_W'(1) : GRID_W'(2));
        return (v >= lo) && (v <= hi);
    endfunction

    axis_t lst_x, lst_y, ref_x, ref_y;
    logic [WIN_CELLS-1:0] sel_mask;
    logic [GRID_W-1:0]    vx, vy;
    logic                 exists, member, pick;

    always_comb
    begin
        if (w_op_reg == OP_LEAVE)
        begin
            lst_x = w_ox_reg; lst_y = w_oy_reg;
            ref_x = w_nx_reg; ref_y = w_ny_reg;
        end
        else
        begin
            lst_x = w_nx_reg; lst_y = w_ny_reg;
            ref_x = w_ox_reg; ref_y = w_oy_reg;
        end
        sel_mask = '0;
        vx = '0; vy = '0; exists = 1'b0; member = 1'b0; pick = 1'b0;
        for (int i = 0; i < WIN_SIDE; i++)
        begin
            for (int j = 0; j < WIN_SIDE; j++)
            begin
                vx     = {1'b0, lst_x.lo} + GRID_W'(i);
                vy     = {1'b0, lst_y.lo} + GRID_W'(j);
                exists = !(lst_x.narrow && i == WIN_SIDE - 1) &&
                         !(lst_y.narrow && j == WIN_SIDE - 1);
                member = in_axis(vx, ref_x) && in_axis(vy, ref_y);
                case (w_op_reg)
                    OP_ENTER: pick = !member;
                    OP_LEAVE: pick = !member;
                    OP_KEEP:  pick = member;
                    default:  pick = 1'b1;
                endcase
                sel_mask[i*WIN_SIDE+j] = exists && pick;
            end
        end
    end

    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [WIN_CELLS-1:0] m_mask_reg;
    logic [CELL_W-1:0]    m_bx_reg, m_by_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (advance)
            m_valid_reg <= w_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_mask_reg <= sel_mask;
            m_bx_reg   <= lst_x.lo;
            m_by_reg   <= lst_y.lo;
            if (!w_inside_reg)
                m_status_reg <= ST_OUT;
            else if (sel_mask == '0)
                m_status_reg <= ST_EMPTY;
            else
                m_status_reg <= ST_CELL;
        end
    end

    // Output stage: sends one selected cell per cycle, lowest index first.
    logic [1:0]           o_status_reg;
    logic [WIN_CELLS-1:0] o_mask_reg, o_mask_next;
    logic [CELL_W-1:0]    o_bx_reg, o_by_reg;
    logic [WIN_CELLS-1:0] first_bit;
    logic [1:0]           off_x, off_y;
    logic                 found;

    always_comb
    begin
        first_bit = '0;
        off_x     = '0;
        off_y     = '0;
        found     = 1'b0;
        for (int i = 0; i < WIN_SIDE; i++)
        begin
            for (int j = 0; j < WIN_SIDE; j++)
            begin
                if (!found && o_mask_reg[i*WIN_SIDE+j])
                begin
                    found                   = 1'b1;
                    first_bit[i*WIN_SIDE+j] = 1'b1;
                    off_x                   = 2'(i);
                    off_y                   = 2'(j);
                end
            end
        end
        o_mask_next = o_mask_reg & ~first_bit;
        if (o_status_reg == ST_CELL)
        begin
            res_word.cell_x = o_bx_reg + CELL_W'(off_x);
            res_word.cell_y = o_by_reg + CELL_W'(off_y);
            res_word.last   = (o_mask_next == '0);
        end
        else
        begin
            res_word.cell_x = '0;
            res_word.cell_y = '0;
            res_word.last   = 1'b1;
        end
        res_word.status = o_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (advance)
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_status_reg <= m_status_reg;
            o_mask_reg   <= m_mask_reg;
            o_bx_reg     <= m_bx_reg;
            o_by_reg     <= m_by_reg;
        end
        else
        begin
            o_mask_reg <= o_mask_next;
        end
    end

    assign done   = o_valid_reg;
    assign result = res_word;

    // A burst that has not ended continues in the next cycle.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |=> done)
        else $error("burst broke off before its last cell");

    // Status words stand alone.
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_CELL) |-> result.last)
        else $error("status word not marked last");

    // While the pipeline is held, the input stage keeps its word.
    a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> (a_valid_reg == $past(a_valid_reg) &&
                  w_valid_reg == $past(w_valid_reg)))
        else $error("pipeline moved during hold");

    // Only cell words can ever be followed by more words of the same item.
    a_cells_only_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |=> (result.status == ST_CELL))
        else $error("non-cell word inside a burst");

endmodule

`default_nettype wire
